// File: hdl/pdk_pkg.sv
// shared types, constants and helpers for the pair distance / kappa squared block
package pdk_pkg;

  // field widths
  localparam int POS_W   = 24;
  localparam int DIP_W   = 16;
  localparam int DIST_W  = 25;
  localparam int KAPPA_W = 19;
  localparam int CNT_W   = 13;
  localparam int CFG_W   = 13;
  localparam int CIDX_W  = 2;

  // default matrix limit
  localparam int DEF_MAX_POINTS = 4096;

  // kappa squared constants, Q3.16
  localparam logic [KAPPA_W-1:0] KAPPA2_ISO = 19'd43691;
  localparam logic [KAPPA_W-1:0] KAPPA2_MAX = 19'd262144;

  // last iteration indexes of the shared root / divide unit
  localparam logic [4:0] SQRT_LAST = 5'd31;
  localparam logic [4:0] DIV_LAST  = 5'd30;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] REG_ORIENTED = 2'd0;
  localparam logic [CIDX_W-1:0] REG_DONORS   = 2'd1;
  localparam logic [CIDX_W-1:0] REG_ACCEPTORS = 2'd2;

  // vector codes: donor dipole, acceptor dipole, separation
  localparam logic [1:0] VEC_D = 2'd0;
  localparam logic [1:0] VEC_A = 2'd1;
  localparam logic [1:0] VEC_R = 2'd2;

  // component and cosine indexes
  localparam logic [1:0] IDX_LAST = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_ACC_CLR,
    OP_SQ_MUL,
    OP_ACC_ADD,
    OP_SQRT_INIT_ACC,
    OP_SQRT_INIT_Q,
    OP_SQRT_STEP,
    OP_DIST_SAVE,
    OP_NORM_INIT,
    OP_NORM_STEP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_UNIT_SAVE,
    OP_OPA_LOAD,
    OP_DOT_MUL,
    OP_COS_SAVE,
    OP_K_MUL,
    OP_K_SUM,
    OP_K_ABS,
    OP_K_SQ,
    OP_K_FIN,
    OP_OUT
  } dp_op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ_CLR,
    ST_SQ_MUL,
    ST_SQ_ADD,
    ST_RT_INIT,
    ST_RT_STEP,
    ST_DIST_SAVE,
    ST_NM_INIT,
    ST_NM_STEP,
    ST_NR_INIT,
    ST_NR_STEP,
    ST_DV_INIT,
    ST_DV_STEP,
    ST_UNIT_SAVE,
    ST_DOT_CLR,
    ST_DOT_OPA,
    ST_DOT_MUL,
    ST_DOT_ADD,
    ST_COS_SAVE,
    ST_K_MUL,
    ST_K_SUM,
    ST_K_ABS,
    ST_K_SQ,
    ST_K_FIN,
    ST_OUT
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] vsel;
    logic [1:0] csel;
    logic [1:0] ksel;
  } dp_cmd_t;

  typedef struct packed {
    logic norm_done;
    logic oriented;
    logic out_free;
  } dp_status_t;

  // first and second vector of each cosine: da, dr, ar
  function automatic logic [1:0] dot_vec_a(input logic [1:0] k);
    logic [1:0] v;
    v = (k == 2'd2) ? VEC_A : VEC_D;
    return v;
  endfunction

  function automatic logic [1:0] dot_vec_b(input logic [1:0] k);
    logic [1:0] v;
    v = (k == 2'd0) ? VEC_A : VEC_R;
    return v;
  endfunction

endpackage

// File: hdl/pdk_ctrl.sv
// sequencer that steps the datapath through one pair
module pdk_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  pdk_pkg::dp_status_t status,
  output pdk_pkg::dp_cmd_t    cmd
);
  import pdk_pkg::*;

  ctrl_state_t state, state_next;
  logic [1:0]  ci;
  logic [1:0]  vi;
  logic [1:0]  k;
  logic [4:0]  cnt;

  assign in_stall = (state != ST_IDLE);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (in_valid) state_next = ST_SQ_CLR;
      ST_SQ_CLR:    state_next = ST_SQ_MUL;
      ST_SQ_MUL:    state_next = ST_SQ_ADD;
      ST_SQ_ADD: begin
        if (ci != IDX_LAST) state_next = ST_SQ_MUL;
        else if (vi == VEC_R) state_next = ST_RT_INIT;
        else state_next = ST_NM_INIT;
      end
      ST_RT_INIT:   state_next = ST_RT_STEP;
      ST_RT_STEP:   if (cnt == SQRT_LAST) state_next = ST_DIST_SAVE;
      ST_DIST_SAVE: state_next = status.oriented ? ST_NM_INIT : ST_OUT;
      ST_NM_INIT:   state_next = ST_NM_STEP;
      ST_NM_STEP:   if (status.norm_done) state_next = ST_NR_INIT;
      ST_NR_INIT:   state_next = ST_NR_STEP;
      ST_NR_STEP:   if (cnt == SQRT_LAST) state_next = ST_DV_INIT;
      ST_DV_INIT:   state_next = ST_DV_STEP;
      ST_DV_STEP:   if (cnt == DIV_LAST) state_next = ST_UNIT_SAVE;
      ST_UNIT_SAVE: begin
        if (ci != IDX_LAST) state_next = ST_DV_INIT;
        else if (vi == VEC_A) state_next = ST_DOT_CLR;
        else state_next = ST_SQ_CLR;
      end
      ST_DOT_CLR:   state_next = ST_DOT_OPA;
      ST_DOT_OPA:   state_next = ST_DOT_MUL;
      ST_DOT_MUL:   state_next = ST_DOT_ADD;
      ST_DOT_ADD:   state_next = (ci == IDX_LAST) ? ST_COS_SAVE : ST_DOT_OPA;
      ST_COS_SAVE:  state_next = (k == IDX_LAST) ? ST_K_MUL : ST_DOT_CLR;
      ST_K_MUL:     state_next = ST_K_SUM;
      ST_K_SUM:     state_next = ST_K_ABS;
      ST_K_ABS:     state_next = ST_K_SQ;
      ST_K_SQ:      state_next = ST_K_FIN;
      ST_K_FIN:     state_next = ST_OUT;
      ST_OUT:       if (status.out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd.op   = OP_NONE;
    cmd.vsel = vi;
    cmd.csel = ci;
    cmd.ksel = k;
    unique case (state)
      ST_IDLE:      if (in_valid) cmd.op = OP_LOAD;
      ST_SQ_CLR:    cmd.op = OP_ACC_CLR;
      ST_SQ_MUL:    cmd.op = OP_SQ_MUL;
      ST_SQ_ADD:    cmd.op = OP_ACC_ADD;
      ST_RT_INIT:   cmd.op = OP_SQRT_INIT_ACC;
      ST_RT_STEP:   cmd.op = OP_SQRT_STEP;
      ST_DIST_SAVE: cmd.op = OP_DIST_SAVE;
      ST_NM_INIT:   cmd.op = OP_NORM_INIT;
      ST_NM_STEP:   cmd.op = OP_NORM_STEP;
      ST_NR_INIT:   cmd.op = OP_SQRT_INIT_Q;
      ST_NR_STEP:   cmd.op = OP_SQRT_STEP;
      ST_DV_INIT:   cmd.op = OP_DIV_INIT;
      ST_DV_STEP:   cmd.op = OP_DIV_STEP;
      ST_UNIT_SAVE: cmd.op = OP_UNIT_SAVE;
      ST_DOT_CLR:   cmd.op = OP_ACC_CLR;
      ST_DOT_OPA: begin
        cmd.op   = OP_OPA_LOAD;
        cmd.vsel = dot_vec_a(k);
      end
      ST_DOT_MUL: begin
        cmd.op   = OP_DOT_MUL;
        cmd.vsel = dot_vec_b(k);
      end
      ST_DOT_ADD:   cmd.op = OP_ACC_ADD;
      ST_COS_SAVE:  cmd.op = OP_COS_SAVE;
      ST_K_MUL:     cmd.op = OP_K_MUL;
      ST_K_SUM:     cmd.op = OP_K_SUM;
      ST_K_ABS:     cmd.op = OP_K_ABS;
      ST_K_SQ:      cmd.op = OP_K_SQ;
      ST_K_FIN:     cmd.op = OP_K_FIN;
      ST_OUT:       if (status.out_free) cmd.op = OP_OUT;
      default:      cmd.op = OP_NONE;
    endcase
  end

  // state and loop counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ci    <= '0;
      vi    <= VEC_R;
      k     <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          vi <= VEC_R;
          k  <= '0;
        end
        ST_SQ_CLR:  ci <= '0;
        ST_SQ_ADD:  if (ci != IDX_LAST) ci <= ci + 2'd1;
        ST_RT_INIT, ST_NR_INIT, ST_DV_INIT: cnt <= '0;
        ST_RT_STEP, ST_NR_STEP, ST_DV_STEP: cnt <= cnt + 5'd1;
        ST_NM_INIT: ci <= '0;
        ST_UNIT_SAVE: begin
          if (ci != IDX_LAST) begin
            ci <= ci + 2'd1;
          end else begin
            ci <= '0;
            vi <= (vi == VEC_R) ? VEC_D : VEC_A;
          end
        end
        ST_DOT_CLR: ci <= '0;
        ST_DOT_ADD: if (ci != IDX_LAST) ci <= ci + 2'd1;
        ST_COS_SAVE: k <= k + 2'd1;
        default: ;
      endcase
    end
  end

endmodule

// File: hdl/pdk_dp.sv
// datapath: operand store, shared multiplier, root / divide unit, counters, output word
module pdk_dp #(
  parameter int MAX_POINTS = pdk_pkg::DEF_MAX_POINTS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  pdk_pkg::dp_cmd_t                    cmd,
  output pdk_pkg::dp_status_t                 status,
  input  logic signed [pdk_pkg::POS_W-1:0]    donor_x,
  input  logic signed [pdk_pkg::POS_W-1:0]    donor_y,
  input  logic signed [pdk_pkg::POS_W-1:0]    donor_z,
  input  logic signed [pdk_pkg::DIP_W-1:0]    donor_dip_x,
  input  logic signed [pdk_pkg::DIP_W-1:0]    donor_dip_y,
  input  logic signed [pdk_pkg::DIP_W-1:0]    donor_dip_z,
  input  logic signed [pdk_pkg::POS_W-1:0]    acceptor_x,
  input  logic signed [pdk_pkg::POS_W-1:0]    acceptor_y,
  input  logic signed [pdk_pkg::POS_W-1:0]    acceptor_z,
  input  logic signed [pdk_pkg::DIP_W-1:0]    acceptor_dip_x,
  input  logic signed [pdk_pkg::DIP_W-1:0]    acceptor_dip_y,
  input  logic signed [pdk_pkg::DIP_W-1:0]    acceptor_dip_z,
  input  logic                                cfg_we,
  input  logic [pdk_pkg::CIDX_W-1:0]          cfg_index,
  input  logic [pdk_pkg::CFG_W-1:0]           cfg_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [pdk_pkg::DIST_W-1:0]          distance,
  output logic [pdk_pkg::KAPPA_W-1:0]         kappa_squared,
  output logic                                last_pair
);
  import pdk_pkg::*;

  localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  // configuration and pair counters
  logic              oriented_mode;
  logic [CNT_W-1:0]  donor_count;
  logic [CNT_W-1:0]  acceptor_count;
  logic [IDX_W-1:0]  donor_index;
  logic [IDX_W-1:0]  acceptor_index;
  logic [IDX_W-1:0]  donor_lim;
  logic [IDX_W-1:0]  acceptor_lim;
  logic              a_end;
  logic              d_end;

  // operand store and working registers
  logic signed [24:0] comp [0:8];
  logic signed [31:0] unitv [0:8];
  logic signed [32:0] cosv [0:2];
  logic signed [63:0] acc;
  logic signed [63:0] prod;
  logic signed [32:0] opa;
  logic signed [63:0] kq;
  logic [31:0]        km;
  logic [KAPPA_W-1:0] k2;
  logic [DIST_W-1:0]  sep_len;
  logic [63:0]        q;
  logic [4:0]         sh;
  logic               zvec;
  logic [63:0]        sv;
  logic [34:0]        sq_rem;
  logic [31:0]        sq_root;
  logic [32:0]        dv_rem;
  logic [30:0]        dv_quot;
  logic               dv_first;

  logic [3:0]         idx;
  logic signed [24:0] comp_rd;
  logic [24:0]        comp_mag;
  logic signed [31:0] unit_rd;
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] mul_p;
  logic [34:0]        sq_shift;
  logic [34:0]        sq_trial;
  logic [55:0]        dv_num;
  logic [32:0]        dv_t;
  logic [32:0]        dv_n;
  logic signed [63:0] kf;
  logic [63:0]        kmag;
  logic [63:0]        rnd;
  logic [19:0]        k2_raw;
  logic [31:0]        unit_mag;
  logic               out_take;

  // operand selection
  assign idx      = ({2'b00, cmd.vsel} * 4'd3) + {2'b00, cmd.csel};
  assign comp_rd  = comp[idx];
  assign comp_mag = comp_rd[24] ? 25'(-comp_rd) : 25'(comp_rd);
  assign unit_rd  = unitv[idx];

  // matrix limits, count of zero means one
  assign donor_lim = (donor_count == '0) ? '0 :
                     (32'(donor_count) > MAX_POINTS) ? IDX_W'(MAX_POINTS - 1) :
                     IDX_W'(donor_count - 13'd1);
  assign acceptor_lim = (acceptor_count == '0) ? '0 :
                        (32'(acceptor_count) > MAX_POINTS) ? IDX_W'(MAX_POINTS - 1) :
                        IDX_W'(acceptor_count - 13'd1);
  assign a_end = (acceptor_index >= acceptor_lim);
  assign d_end = (donor_index >= donor_lim);

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_SQ_MUL: begin
        mul_a = 33'(comp_rd);
        mul_b = 33'(comp_rd);
      end
      OP_DOT_MUL: begin
        mul_a = opa;
        mul_b = 33'(unit_rd);
      end
      OP_K_MUL: begin
        mul_a = cosv[1];
        mul_b = cosv[2];
      end
      OP_K_SQ: begin
        mul_a = $signed({1'b0, km});
        mul_b = $signed({1'b0, km});
      end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // one root bit per step
  assign sq_shift = {sq_rem[32:0], sv[63:62]};
  assign sq_trial = {1'b0, sq_root, 2'b01};

  // one quotient bit per step
  assign dv_num = 56'(comp_mag) << sh;
  assign dv_t   = dv_first ? dv_rem : {dv_rem[31:0], 1'b0};
  assign dv_n   = {1'b0, sq_root};

  // kappa magnitude and rounded square
  assign kf       = kq >>> 30;
  assign kmag     = kf[63] ? 64'(-kf) : 64'(kf);
  assign rnd      = 64'(prod) + 64'h0000_0800_0000_0000;
  assign k2_raw   = rnd[63:44];
  assign unit_mag = {1'b0, dv_quot};

  assign status.norm_done = zvec || (q[63:60] != 4'd0);
  assign status.oriented  = oriented_mode;
  assign status.out_free  = !out_valid || !out_stall;
  assign out_take         = (cmd.op == OP_OUT);

  // arithmetic registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        comp[0] <= 25'(donor_dip_x);
        comp[1] <= 25'(donor_dip_y);
        comp[2] <= 25'(donor_dip_z);
        comp[3] <= 25'(acceptor_dip_x);
        comp[4] <= 25'(acceptor_dip_y);
        comp[5] <= 25'(acceptor_dip_z);
        comp[6] <= 25'(donor_x) - 25'(acceptor_x);
        comp[7] <= 25'(donor_y) - 25'(acceptor_y);
        comp[8] <= 25'(donor_z) - 25'(acceptor_z);
      end
      OP_ACC_CLR: acc <= '0;
      OP_SQ_MUL, OP_DOT_MUL, OP_K_MUL, OP_K_SQ: prod <= mul_p[63:0];
      OP_ACC_ADD: acc <= acc + prod;
      OP_SQRT_INIT_ACC, OP_SQRT_INIT_Q: begin
        sv      <= (cmd.op == OP_SQRT_INIT_Q) ? q : 64'(acc);
        sq_rem  <= '0;
        sq_root <= '0;
      end
      OP_SQRT_STEP: begin
        sv <= {sv[61:0], 2'b00};
        if (sq_shift >= sq_trial) begin
          sq_rem  <= sq_shift - sq_trial;
          sq_root <= {sq_root[30:0], 1'b1};
        end else begin
          sq_rem  <= sq_shift;
          sq_root <= {sq_root[30:0], 1'b0};
        end
      end
      OP_DIST_SAVE: sep_len <= sq_root[DIST_W-1:0];
      OP_NORM_INIT: begin
        q    <= 64'(acc);
        sh   <= '0;
        zvec <= (acc == '0);
      end
      OP_NORM_STEP: begin
        if (!status.norm_done) begin
          q  <= {q[61:0], 2'b00};
          sh <= sh + 5'd1;
        end
      end
      OP_DIV_INIT: begin
        dv_rem   <= dv_num[32:0];
        dv_quot  <= '0;
        dv_first <= 1'b1;
      end
      OP_DIV_STEP: begin
        dv_first <= 1'b0;
        if (dv_t >= dv_n) begin
          dv_rem  <= dv_t - dv_n;
          dv_quot <= {dv_quot[29:0], 1'b1};
        end else begin
          dv_rem  <= dv_t;
          dv_quot <= {dv_quot[29:0], 1'b0};
        end
      end
      OP_UNIT_SAVE: begin
        if (zvec) unitv[idx] <= '0;
        else if (comp_rd[24]) unitv[idx] <= -$signed(unit_mag);
        else unitv[idx] <= $signed(unit_mag);
      end
      OP_OPA_LOAD: opa <= 33'(unit_rd);
      OP_COS_SAVE: cosv[cmd.ksel] <= acc[62:30];
      OP_K_SUM:    kq <= $signed({cosv[0][32], cosv[0], 30'd0}) - (prod + (prod <<< 1));
      OP_K_ABS:    km <= (kmag > 64'h0000_0000_8000_0000) ? 32'h8000_0000 : kmag[31:0];
      OP_K_FIN:    k2 <= (k2_raw > 20'(KAPPA2_MAX)) ? KAPPA2_MAX : k2_raw[KAPPA_W-1:0];
      default: ;
    endcase
  end

  // output word
  always_ff @(posedge clk) begin
    if (out_take) begin
      distance      <= sep_len;
      kappa_squared <= oriented_mode ? k2 : KAPPA2_ISO;
      last_pair     <= a_end && d_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // configuration registers and pair counters
  always_ff @(posedge clk) begin
    if (rst) begin
      oriented_mode  <= 1'b0;
      donor_count    <= 13'd1;
      acceptor_count <= 13'd1;
      donor_index    <= '0;
      acceptor_index <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ORIENTED: oriented_mode <= cfg_data[0];
        REG_DONORS: begin
          donor_count    <= cfg_data;
          donor_index    <= '0;
          acceptor_index <= '0;
        end
        REG_ACCEPTORS: begin
          acceptor_count <= cfg_data;
          donor_index    <= '0;
          acceptor_index <= '0;
        end
        default: ;
      endcase
    end else if (out_take) begin
      if (a_end) begin
        acceptor_index <= '0;
        donor_index    <= d_end ? '0 : donor_index + 1'b1;
      end else begin
        acceptor_index <= acceptor_index + 1'b1;
      end
    end
  end

endmodule

// File: hdl/pair_distance_kappa2_top.sv
// Pair distance and kappa squared: one donor/acceptor pair per word in, one result word out.
// Each accepted word gives its separation (Q17.8) and the orientation factor kappa squared
// (Q3.16, saturated at 4.0). With oriented_mode clear the separation root alone runs
// through the one-bit-per-cycle root unit. With oriented_mode set the shared root / divide
// unit also resolves one bit per cycle for three norms and nine unit components, plus the
// normalize steps of each vector. One pair is worked at a time; the output register lets
// the next word in while a result still waits. last_pair marks the final pair of the
// donor_count x acceptor_count matrix.
module pair_distance_kappa2_top #(
  parameter int MAX_POINTS = pdk_pkg::DEF_MAX_POINTS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [pdk_pkg::POS_W-1:0]    donor_x,
  input  logic signed [pdk_pkg::POS_W-1:0]    donor_y,
  input  logic signed [pdk_pkg::POS_W-1:0]    donor_z,
  input  logic signed [pdk_pkg::DIP_W-1:0]    donor_dip_x,
  input  logic signed [pdk_pkg::DIP_W-1:0]    donor_dip_y,
  input  logic signed [pdk_pkg::DIP_W-1:0]    donor_dip_z,
  input  logic signed [pdk_pkg::POS_W-1:0]    acceptor_x,
  input  logic signed [pdk_pkg::POS_W-1:0]    acceptor_y,
  input  logic signed [pdk_pkg::POS_W-1:0]    acceptor_z,
  input  logic signed [pdk_pkg::DIP_W-1:0]    acceptor_dip_x,
  input  logic signed [pdk_pkg::DIP_W-1:0]    acceptor_dip_y,
  input  logic signed [pdk_pkg::DIP_W-1:0]    acceptor_dip_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [pdk_pkg::DIST_W-1:0]          distance,
  output logic [pdk_pkg::KAPPA_W-1:0]         kappa_squared,
  output logic                                last_pair,
  input  logic                                cfg_we,
  input  logic [pdk_pkg::CIDX_W-1:0]          cfg_index,
  input  logic [pdk_pkg::CFG_W-1:0]           cfg_data
);
  import pdk_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer
  pdk_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath
  pdk_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .donor_x        (donor_x),
    .donor_y        (donor_y),
    .donor_z        (donor_z),
    .donor_dip_x    (donor_dip_x),
    .donor_dip_y    (donor_dip_y),
    .donor_dip_z    (donor_dip_z),
    .acceptor_x     (acceptor_x),
    .acceptor_y     (acceptor_y),
    .acceptor_z     (acceptor_z),
    .acceptor_dip_x (acceptor_dip_x),
    .acceptor_dip_y (acceptor_dip_y),
    .acceptor_dip_z (acceptor_dip_z),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .distance       (distance),
    .kappa_squared  (kappa_squared),
    .last_pair      (last_pair)
  );

endmodule

// File: tb/pair_distance_kappa2_top_tb.sv
// testbench for the pair distance / kappa squared block: directed and random pairs checked against a local predictor
`timescale 1ns / 100ps

module pair_distance_kappa2_top_tb;
  import pdk_pkg::*;

  typedef struct packed {
    logic signed [POS_W-1:0] donor_x, donor_y, donor_z;
    logic signed [DIP_W-1:0] donor_dip_x, donor_dip_y, donor_dip_z;
    logic signed [POS_W-1:0] acceptor_x, acceptor_y, acceptor_z;
    logic signed [DIP_W-1:0] acceptor_dip_x, acceptor_dip_y, acceptor_dip_z;
  } pair_t;

  typedef struct packed {
    logic [DIST_W-1:0]  distance;
    logic [KAPPA_W-1:0] kappa_squared;
    logic               last_pair;
  } pair_result_t;

  localparam logic [KAPPA_W-1:0] KAPPA_ISO_EXP = 19'd43691;
  localparam int unsigned        KAPPA_CAP     = 262144;
  localparam int                 LONG_HOLD     = 2500;
  localparam int                 SETTLE        = 800;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [DIST_W-1:0]   distance;
  logic [KAPPA_W-1:0]  kappa_squared;
  logic                last_pair;
  logic                cfg_we = 1'b0;
  logic [CIDX_W-1:0]   cfg_index = REG_ORIENTED;
  logic [CFG_W-1:0]    cfg_data = '0;
  pair_t               cur = '0;

  // mirrored configuration and matrix position
  logic                oriented_cfg = 1'b0;
  int unsigned         donors_cfg = 1;
  int unsigned         acceptors_cfg = 1;
  int unsigned         donor_pos = 0;
  int unsigned         acceptor_pos = 0;

  pair_t               pending_pairs[$];
  pair_result_t        expected_results[$];
  int                  mismatches = 0;
  int                  words_in = 0;
  int                  words_out = 0;
  int                  last_marks = 0;
  int                  burst_left = 0;
  int                  gap_left = 0;
  bit                  hold_send = 0;
  bit                  long_hold_req = 0;
  bit                  long_hold_done = 0;
  int                  hold_cnt = 0;
  int                  stall_tick = 0;

  pair_distance_kappa2_top dut (
    .clk, .rst, .in_valid, .in_stall,
    .donor_x(cur.donor_x), .donor_y(cur.donor_y), .donor_z(cur.donor_z),
    .donor_dip_x(cur.donor_dip_x), .donor_dip_y(cur.donor_dip_y),
    .donor_dip_z(cur.donor_dip_z),
    .acceptor_x(cur.acceptor_x), .acceptor_y(cur.acceptor_y), .acceptor_z(cur.acceptor_z),
    .acceptor_dip_x(cur.acceptor_dip_x), .acceptor_dip_y(cur.acceptor_dip_y),
    .acceptor_dip_z(cur.acceptor_dip_z),
    .out_valid, .out_stall, .distance, .kappa_squared, .last_pair,
    .cfg_we, .cfg_index, .cfg_data
  );

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  // fixed-point arithmetic of the pair computation
  function automatic longint unsigned abs64(input longint x);
    return x < 0 ? longint'(-x) : longint'(x);
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // unit vector in Q1.30, zero vector stays zero
  function automatic void normalize(input longint c [3], output longint u [3]);
    longint unsigned q, n, v;
    int unsigned s;
    q = 0;
    s = 0;
    for (int i = 0; i < 3; i++) q += abs64(c[i]) * abs64(c[i]);
    if (q == 0) begin
      for (int i = 0; i < 3; i++) u[i] = 0;
      return;
    end
    while (q < (64'd1 << 60)) begin
      q = q << 2;
      s += 2;
    end
    n = int_sqrt(q);
    for (int i = 0; i < 3; i++) begin
      v = (abs64(c[i]) << (30 + s / 2)) / n;
      u[i] = c[i] < 0 ? -longint'(v) : longint'(v);
    end
  endfunction

  function automatic longint cosine(input longint a [3], input longint b [3]);
    longint acc;
    acc = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    return acc >>> 30;
  endfunction

  // distance and kappa squared of one pair
  function automatic pair_result_t pair_geometry(input pair_t p, input logic oriented);
    pair_result_t    res;
    longint          sep [3], dd [3], ad [3], du [3], au [3], ru [3];
    longint unsigned r2, km, k2;
    longint          c_da, c_dr, c_ar, kq;
    sep[0] = longint'(p.donor_x) - longint'(p.acceptor_x);
    sep[1] = longint'(p.donor_y) - longint'(p.acceptor_y);
    sep[2] = longint'(p.donor_z) - longint'(p.acceptor_z);
    dd[0] = longint'(p.donor_dip_x);
    dd[1] = longint'(p.donor_dip_y);
    dd[2] = longint'(p.donor_dip_z);
    ad[0] = longint'(p.acceptor_dip_x);
    ad[1] = longint'(p.acceptor_dip_y);
    ad[2] = longint'(p.acceptor_dip_z);
    r2 = 0;
    for (int i = 0; i < 3; i++) r2 += abs64(sep[i]) * abs64(sep[i]);
    res.distance = DIST_W'(int_sqrt(r2));
    res.last_pair = 1'b0;
    if (!oriented) begin
      res.kappa_squared = KAPPA_ISO_EXP;
    end else begin
      normalize(dd, du);
      normalize(ad, au);
      normalize(sep, ru);
      c_da = cosine(du, au);
      c_dr = cosine(du, ru);
      c_ar = cosine(au, ru);
      kq = c_da * (64'sd1 <<< 30) - 3 * (c_dr * c_ar);
      km = abs64(kq >>> 30);
      if (km > (64'd1 << 31)) km = 64'd1 << 31;
      k2 = (km * km + (64'd1 << 43)) >> 44;
      if (k2 > KAPPA_CAP) k2 = 64'(KAPPA_CAP);
      res.kappa_squared = KAPPA_W'(k2);
    end
    return res;
  endfunction

  function automatic int unsigned clamp_count(input int unsigned c);
    if (c == 0) return 1;
    if (c > DEF_MAX_POINTS) return DEF_MAX_POINTS;
    return c;
  endfunction

  // stimulus builders
  function automatic pair_t make_pair(input longint dx, dy, dz, ddx, ddy, ddz,
                                      input longint ax, ay, az, adx, ady, adz);
    pair_t p;
    p.donor_x = POS_W'(dx);  p.donor_y = POS_W'(dy);  p.donor_z = POS_W'(dz);
    p.donor_dip_x = DIP_W'(ddx); p.donor_dip_y = DIP_W'(ddy); p.donor_dip_z = DIP_W'(ddz);
    p.acceptor_x = POS_W'(ax); p.acceptor_y = POS_W'(ay); p.acceptor_z = POS_W'(az);
    p.acceptor_dip_x = DIP_W'(adx); p.acceptor_dip_y = DIP_W'(ady);
    p.acceptor_dip_z = DIP_W'(adz);
    return p;
  endfunction

  function automatic pair_t random_pair();
    pair_t        p;
    logic [255:0] raw;
    int           kind;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    p = raw[$bits(pair_t)-1:0];
    kind = $urandom_range(0, 9);
    case (kind)
      // zero donor dipole
      1: {p.donor_dip_x, p.donor_dip_y, p.donor_dip_z} = '0;
      // zero acceptor dipole
      2: {p.acceptor_dip_x, p.acceptor_dip_y, p.acceptor_dip_z} = '0;
      // coincident positions
      3: {p.acceptor_x, p.acceptor_y, p.acceptor_z} = {p.donor_x, p.donor_y, p.donor_z};
      // close positions, long normalize
      4: begin
        p.acceptor_x = POS_W'(p.donor_x + $signed(POS_W'($urandom_range(0, 6))) - 3);
        p.acceptor_y = POS_W'(p.donor_y + $signed(POS_W'($urandom_range(0, 6))) - 3);
        p.acceptor_z = p.donor_z;
      end
      // tiny dipoles
      5: begin
        p.donor_dip_x = DIP_W'($signed(DIP_W'($urandom_range(0, 4))) - 2);
        p.donor_dip_y = DIP_W'($signed(DIP_W'($urandom_range(0, 4))) - 2);
        p.acceptor_dip_z = DIP_W'($signed(DIP_W'($urandom_range(0, 2))) - 1);
      end
      // collinear dipoles along the separation
      6: begin
        p.acceptor_x = POS_W'(p.donor_x - 256);
        p.acceptor_y = p.donor_y;
        p.acceptor_z = p.donor_z;
        {p.donor_dip_y, p.donor_dip_z, p.acceptor_dip_y, p.acceptor_dip_z} = '0;
      end
      default: ;
    endcase
    return p;
  endfunction

  // mismatch reporting
  task automatic report(input string what, input longint got, input longint want);
    $display("%0t: mismatch on %s: got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // configuration register write, taken while the block is idle
  task automatic write_reg(input logic [CIDX_W-1:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_W-1:0];
    case (idx)
      REG_ORIENTED: oriented_cfg = val[0];
      REG_DONORS: begin
        donors_cfg = 32'(val[CFG_W-1:0]);
        donor_pos = 0;
        acceptor_pos = 0;
      end
      REG_ACCEPTORS: begin
        acceptors_cfg = 32'(val[CFG_W-1:0]);
        donor_pos = 0;
        acceptor_pos = 0;
      end
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait until every queued word is in and every result is out
  task automatic drain();
    while (pending_pairs.size() != 0 || in_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_matrix(input logic oriented, input int unsigned nd, input int unsigned na);
    write_reg(REG_ORIENTED, 32'(oriented));
    write_reg(REG_DONORS, nd);
    write_reg(REG_ACCEPTORS, na);
  endtask

  task automatic queue_random(input int n);
    repeat (n) pending_pairs.push_back(random_pair());
  endtask

  // sender: bursts of words with random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (hold_send || pending_pairs.size() == 0) begin
        in_valid <= 1'b0;
      end else begin
        cur <= pending_pairs.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // predict each accepted word and advance the matrix position
  always @(posedge clk) begin
    pair_result_t res;
    bit a_end, d_end;
    if (!rst && in_valid && !in_stall) begin
      res = pair_geometry(cur, oriented_cfg);
      a_end = acceptor_pos >= clamp_count(acceptors_cfg) - 1;
      d_end = donor_pos >= clamp_count(donors_cfg) - 1;
      res.last_pair = a_end && d_end;
      if (a_end) begin
        acceptor_pos = 0;
        donor_pos = d_end ? 0 : donor_pos + 1;
      end else begin
        acceptor_pos++;
      end
      expected_results.push_back(res);
      words_in++;
    end
  end

  // receiver: stall pattern that rotates through four characters, plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_cnt != 0) begin
      out_stall <= 1'b1;
      hold_cnt <= hold_cnt - 1;
    end else if (long_hold_req && !long_hold_done) begin
      out_stall <= 1'b1;
      hold_cnt <= LONG_HOLD;
      long_hold_done <= 1'b1;
    end else begin
      stall_tick <= stall_tick + 1;
      case ((stall_tick / 64) % 4)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 1) == 1);
        2: out_stall <= (stall_tick % 3) == 0;
        default: out_stall <= $urandom_range(0, 4) != 0;
      endcase
    end
  end

  // result checker
  always @(posedge clk) begin
    pair_result_t want;
    if (!rst && out_valid && !out_stall) begin
      words_out++;
      if (last_pair) last_marks++;
      if (expected_results.size() == 0) begin
        report("unexpected result word", longint'(distance), -1);
      end else begin
        want = expected_results.pop_front();
        if (distance !== want.distance)
          report("distance", longint'(distance), longint'(want.distance));
        if (kappa_squared !== want.kappa_squared)
          report("kappa_squared", longint'(kappa_squared), longint'(want.kappa_squared));
        if (last_pair !== want.last_pair)
          report("last_pair", longint'(last_pair), longint'(want.last_pair));
      end
    end
  end

  // watchdog
  initial begin
    #40ms;
    $display("FAIL pair_distance_kappa2_top");
    $finish;
  end

  // test sequence
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset configuration: isotropic, 1 x 1
    pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_pairs.push_back(make_pair(8388607, 8388607, 8388607, 1, 2, 3,
                                      -8388608, -8388608, -8388608, 4, 5, 6));
    queue_random(3);
    drain();

    // directed oriented pairs, then random ones
    set_matrix(1'b1, 2, 3);
    pending_pairs.push_back(make_pair(-8388608, -8388608, -8388608, -32768, -32768, -32768,
                                      8388607, 8388607, 8388607, 32767, 32767, 32767));
    pending_pairs.push_back(make_pair(100, 0, 0, 0, 0, 0, 0, 0, 0, 5, 0, 0));
    pending_pairs.push_back(make_pair(100, 0, 0, 7, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_pairs.push_back(make_pair(5, 5, 5, 1, 0, 0, 5, 5, 5, 1, 0, 0));
    pending_pairs.push_back(make_pair(5, 5, 5, 1, 0, 0, 5, 5, 5, 0, 1, 0));
    pending_pairs.push_back(make_pair(256, 0, 0, 300, 0, 0, 0, 0, 0, 300, 0, 0));
    pending_pairs.push_back(make_pair(256, 0, 0, -32768, 0, 0, 0, 0, 0, 32767, 0, 0));
    pending_pairs.push_back(make_pair(0, 256, 0, 1, 0, 0, 0, 0, 0, 0, 1, 0));
    pending_pairs.push_back(make_pair(0, 0, 1, 32767, -32768, 1, 0, 0, 0, -1, 1, 32767));
    pending_pairs.push_back(make_pair(1, 1, 1, 1, 1, 1, 0, 0, 0, -1, -1, -1));
    pending_pairs.push_back(make_pair(8388607, 0, 0, 0, 32767, 0, -8388608, 0, 0, 0, 0,
                                      32767));
    pending_pairs.push_back(make_pair(-1, -1, -1, -1, -1, -1, 0, 0, 0, 0, 0, 0));
    queue_random(6);
    drain();

    // count extremes: zero and above the limit, then the largest legal counts
    set_matrix(1'b1, 0, 8191);
    queue_random(5);
    drain();
    set_matrix(1'b0, 4096, 4096);
    queue_random(5);
    drain();

    // receiver holds off while the sender keeps going
    set_matrix(1'b0, 3, 4);
    queue_random(40);
    long_hold_req <= 1'b1;
    drain();

    // random matrices, mostly oriented, with a sender pause in the middle
    for (int ph = 0; ph < 5; ph++) begin
      set_matrix(($urandom_range(0, 4) != 0), $urandom_range(1, 6), $urandom_range(1, 6));
      queue_random(35);
      while (pending_pairs.size() != 0 || in_valid) @(posedge clk);
      if (ph == 2) begin
        hold_send = 1;
        while (expected_results.size() != 0) @(posedge clk);
        hold_send = 0;
      end
      queue_random(35);
      drain();
    end

    // last phase back to isotropic with one row of acceptors
    set_matrix(1'b0, 1, 7);
    queue_random(20);
    drain();

    $display("covered %0d pairs in, %0d results out, %0d matrix ends marked",
             words_in, words_out, last_marks);
    $display("isotropic and oriented modes, count extremes, long output hold, sender pause");
    while (expected_results.size() != 0) begin
      void'(expected_results.pop_front());
      report("missing result word", 0, 1);
    end
    if (mismatches == 0) begin
      $display("PASS pair_distance_kappa2_top");
    end else begin
      $display("FAIL pair_distance_kappa2_top");
    end
    $finish;
  end

endmodule
